>>> hw/rtl/brmc_pkg.sv
// Shared types and constants of the register machine execution core.
// Holds the opcode enum, the queued instruction record and the result record.
// No dependencies; every other file of the core imports it.
`default_nettype none

package brmc_pkg;

  localparam int unsigned PC_BITS_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned NUM_REGS        = 16;
  localparam int unsigned REG_IDX_W       = 4;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OFFSET_W        = 8;
  localparam int unsigned DELTA_W         = 10;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned FETCH_W         = 16;
  localparam int unsigned IN_TDATA_W      = 48;
  localparam int unsigned IN_TUSER_W      = 3;
  localparam int unsigned OUT_TDATA_W     = 88;

  typedef enum logic [2:0] {
    OP_RET   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MOV   = 3'd3,
    OP_MOVI  = 3'd4,
    OP_BR    = 3'd5,
    OP_BNZ   = 3'd6,
    OP_START = 3'd7
  } op_e;

  // Decoded instruction as it waits in the queue.
  typedef struct packed {
    op_e                        op;
    logic [REG_IDX_W-1:0]       dest;
    logic [REG_IDX_W-1:0]       src;
    logic [DATA_W-1:0]          imm;
    logic signed [DELTA_W-1:0]  br_delta;  // offset plus instruction length
    logic [LEN_W-1:0]           len;       // bytes and machine cycles
  } item_t;

  // Result record; fetch_address sits in the lowest bits.
  typedef struct packed {
    logic              negative_flag;
    logic              zero_flag;
    logic [DATA_W-1:0] total_cycles;
    logic [DATA_W-1:0] return_value;
    logic              finished;
    logic [FETCH_W-1:0] fetch_address;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

>>> hw/rtl/brmc_front.sv
// Front end of the register machine core: accepts instruction transactions
// and classifies them into queue records. Depends on brmc_pkg.
`default_nettype none

module brmc_front (
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [3:0] dest_reg, [7:4] src_reg, [39:8] immediate, [47:40] branch_offset
  input  wire logic [brmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] mode
  input  wire logic [brmc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  wire logic                                q_ready_i,
  output logic                                     push_o,
  output brmc_pkg::item_t                          item_o
);
  import brmc_pkg::*;

  logic [OFFSET_W-1:0] offset;

  assign s_axis_tready = q_ready_i;
  assign push_o        = s_axis_tvalid & q_ready_i;
  assign offset        = s_axis_tdata[47:40];

  always_comb begin
    item_o.op       = op_e'(s_axis_tuser);
    item_o.dest     = s_axis_tdata[3:0];
    item_o.src      = s_axis_tdata[7:4];
    item_o.imm      = s_axis_tdata[39:8];
    // taken branches land relative to the end of the two-byte instruction
    item_o.br_delta = {{(DELTA_W-OFFSET_W){offset[OFFSET_W-1]}}, offset} + DELTA_W'(2);
    unique case (item_o.op)
      OP_RET: begin
        item_o.len = LEN_W'(1);
      end
      OP_ADD, OP_SUB, OP_MOV: begin
        item_o.len = LEN_W'(2);
      end
      OP_MOVI: begin
        item_o.len = LEN_W'(6);
      end
      OP_BR, OP_BNZ: begin
        item_o.len = LEN_W'(2);
      end
      OP_START: begin
        item_o.len = LEN_W'(0);
      end
      default: begin
        item_o.len = LEN_W'(0);
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/brmc_queue.sv
// Short instruction queue between front end and execution back end.
// Depends on brmc_pkg for the queued record type.
`default_nettype none

module brmc_queue #(
  parameter int unsigned DEPTH = brmc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire brmc_pkg::item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output brmc_pkg::item_t      item_o,
  input  wire logic            pop_i
);
  import brmc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q,  count_d;
  logic               do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/brmc_back.sv
// Execution back end: register file, flags, pc, cycle count and result register.
// Pops decoded instructions from the queue. Depends on brmc_pkg.
`default_nettype none

module brmc_back #(
  parameter int unsigned PC_BITS = brmc_pkg::PC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  input  wire brmc_pkg::item_t                    q_item_i,
  output logic                                    pop_o,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [brmc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import brmc_pkg::*;

  // register file storage; entries not valid since the last start read as zero
  logic [DATA_W-1:0]   regs_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q, vld_d;

  logic                ex_valid_q;
  item_t               ex_item_q;
  logic [DATA_W-1:0]   rd_a_q, rd_b_q;
  logic [DATA_W-1:0]   rd_a_d, rd_b_d;

  logic [PC_BITS-1:0]  pc_q, pc_d;
  logic [DATA_W-1:0]   cyc_q, cyc_d;
  logic [DATA_W-1:0]   r0_q, r0_d;
  logic                zf_q, zf_d, nf_q, nf_d, halt_q, halt_d;

  logic                out_valid_q;
  result_t             out_q, out_d;

  logic                ex_fire, pop;
  logic                wr_en, wr_clr;
  logic [REG_IDX_W-1:0] wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [DATA_W-1:0]   sum, diff, br_ext;
  logic [PC_BITS-1:0]  pc_seq, pc_br;

  assign ex_fire = ex_valid_q & (~out_valid_q | m_axis_tready);
  assign pop     = q_valid_i & (~ex_valid_q | ex_fire);
  assign pop_o   = pop;

  assign sum    = rd_a_q + rd_b_q;
  assign diff   = rd_a_q - rd_b_q;
  assign br_ext = {{(DATA_W-DELTA_W){ex_item_q.br_delta[DELTA_W-1]}}, ex_item_q.br_delta};
  assign pc_seq = pc_q + PC_BITS'(ex_item_q.len);
  assign pc_br  = pc_q + br_ext[PC_BITS-1:0];

  // execute the instruction held in the execute register
  always_comb begin
    pc_d    = pc_q;
    cyc_d   = cyc_q;
    zf_d    = zf_q;
    nf_d    = nf_q;
    halt_d  = halt_q;
    wr_en   = 1'b0;
    wr_clr  = 1'b0;
    wr_addr = ex_item_q.dest;
    wr_data = ex_item_q.imm;
    if (ex_item_q.op == OP_START || !halt_q) begin
      unique case (ex_item_q.op)
        OP_START: begin
          pc_d    = '0;
          cyc_d   = '0;
          zf_d    = 1'b0;
          nf_d    = 1'b0;
          halt_d  = 1'b0;
          wr_en   = 1'b1;
          wr_clr  = 1'b1;
          wr_addr = '0;
        end
        OP_RET: begin
          pc_d   = pc_seq;
          cyc_d  = cyc_q + DATA_W'(ex_item_q.len);
          halt_d = 1'b1;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = sum;
          zf_d    = (sum == '0);
          nf_d    = sum[DATA_W-1];
          pc_d    = pc_seq;
          cyc_d   = cyc_q + DATA_W'(ex_item_q.len);
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = diff;
          zf_d    = (diff == '0);
          nf_d    = diff[DATA_W-1];
          pc_d    = pc_seq;
          cyc_d   = cyc_q + DATA_W'(ex_item_q.len);
        end
        OP_MOV: begin
          wr_en   = 1'b1;
          wr_data = rd_b_q;
          pc_d    = pc_seq;
          cyc_d   = cyc_q + DATA_W'(ex_item_q.len);
        end
        OP_MOVI: begin
          wr_en = 1'b1;
          pc_d  = pc_seq;
          cyc_d = cyc_q + DATA_W'(ex_item_q.len);
        end
        OP_BR: begin
          pc_d  = pc_br;
          cyc_d = cyc_q + DATA_W'(ex_item_q.len);
        end
        OP_BNZ: begin
          pc_d  = zf_q ? pc_seq : pc_br;
          cyc_d = cyc_q + DATA_W'(ex_item_q.len);
        end
        default: begin
          pc_d = pc_q;
        end
      endcase
    end
  end

  assign r0_d = (wr_en && wr_addr == '0) ? wr_data : r0_q;

  always_comb begin
    vld_d = vld_q;
    if (ex_fire && wr_clr) begin
      vld_d = NUM_REGS'(1);
    end else if (ex_fire && wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // read at the queue head; forward a write landing at the same edge
  always_comb begin
    if (ex_fire && wr_en && wr_addr == q_item_i.dest) begin
      rd_a_d = wr_data;
    end else if (ex_fire && wr_clr) begin
      rd_a_d = '0;
    end else begin
      rd_a_d = vld_q[q_item_i.dest] ? regs_mem[q_item_i.dest] : '0;
    end
    if (ex_fire && wr_en && wr_addr == q_item_i.src) begin
      rd_b_d = wr_data;
    end else if (ex_fire && wr_clr) begin
      rd_b_d = '0;
    end else begin
      rd_b_d = vld_q[q_item_i.src] ? regs_mem[q_item_i.src] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && wr_en) begin
      regs_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      rd_a_q    <= rd_a_d;
      rd_b_q    <= rd_b_d;
      ex_item_q <= q_item_i;
    end
    if (ex_fire) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d.fetch_address = FETCH_W'(pc_d);
    out_d.finished      = halt_d;
    out_d.return_value  = r0_d;
    out_d.total_cycles  = cyc_d;
    out_d.zero_flag     = zf_d;
    out_d.negative_flag = nf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      cyc_q       <= '0;
      r0_q        <= '0;
      zf_q        <= 1'b0;
      nf_q        <= 1'b0;
      halt_q      <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (pop) begin
        ex_valid_q <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        cyc_q       <= cyc_d;
        r0_q        <= r0_d;
        zf_q        <= zf_d;
        nf_q        <= nf_d;
        halt_q      <= halt_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

`ifndef ASSERT_OFF
  a_ret_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && !halt_q && ex_item_q.op == OP_RET) |=> out_q.finished)
    else $error("return did not set finished");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && ex_item_q.op == OP_START) |=>
      (out_q.total_cycles == '0 && out_q.fetch_address == '0 && !out_q.finished))
    else $error("start left stale state");

  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && wr_en && !wr_clr) |-> !halt_q)
    else $error("register write while halted");

  a_start_valid_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && wr_clr) |=> (vld_q == NUM_REGS'(1)))
    else $error("start did not reset register valid bits");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/bytecode_register_machine_core_top.sv
// Top level of the register machine execution core.
// Depends on brmc_pkg, brmc_front, brmc_queue and brmc_back.
//
// Usage: each slave transaction carries one already fetched instruction
// (mode in tuser, operands in tdata); each one yields exactly one master
// transaction reporting the machine state after that instruction: next fetch
// address, finished, register 0, cycle count and the two flags.
// A result passes the queue write, the pop into the execute register with its
// register read, then the result register. Throughput: one instruction per
// cycle while the receiver keeps tready high, set by the execute stage with
// its forwarded register file read.
// The front end keeps accepting while the queue has room, even when a result
// waits in the output register; when the receiver stalls, hold the result,
// stop the execute stage, let the queue fill, then drop tready.
// Reset: registers, flags, pc, cycle count and the halted state clear at once;
// no sweep, the block accepts in the first cycle after reset.
// After a return every mode but start leaves the state unchanged.
`default_nettype none

module bytecode_register_machine_core_top #(
  parameter int unsigned PC_BITS     = brmc_pkg::PC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = brmc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] dest_reg, [7:4] src_reg, [39:8] immediate, [47:40] branch_offset
  input  wire logic [brmc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] mode
  input  wire logic [brmc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] fetch_address, [16] finished, [48:17] return_value,
  // [80:49] total_cycles, [81] zero_flag, [82] negative_flag, [87:83] zero
  output logic [brmc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import brmc_pkg::*;

  logic  push, q_ready, q_valid, pop;
  item_t push_item, head_item;

  // classify incoming instruction transactions
  brmc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .item_o        (push_item)
  );

  // decouple acceptance from execution
  brmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  // execute and present results
  brmc_back #(
    .PC_BITS (PC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> tb/bytecode_register_machine_core_top_tb.sv
// Self-checking testbench for bytecode_register_machine_core_top.
// Depends on brmc_pkg and the core RTL; a scoreboard class tracks the machine state
// and checks every result transaction in order.
`timescale 1ns / 1ps

module bytecode_register_machine_core_top_tb;
  import brmc_pkg::*;

  localparam int PC_W         = PC_BITS_DEF;
  localparam int PROGRAM_LEN  = 1000;  // counted instructions in the random part
  localparam int QUIET_TAIL   = 120;   // last instructions run with no idling
  localparam int PAUSE_EVERY  = 350;   // drain the core this often
  localparam int STALL_LIMIT  = 2000;  // cycles without any transaction

  // Tracks registers, flags, pc, cycle count and halted state, and holds the
  // reports the core owes in acceptance order.
  class core_state_tracker;
    logic [31:0]     regs [16];
    logic [PC_W-1:0] pc;
    logic            zf;
    logic            nf;
    logic            halted;
    logic [31:0]     cycles;
    result_t         expected_reports [$];
    int              mismatches;

    function void clear_state();
      foreach (regs[i]) regs[i] = '0;
      pc         = '0;
      zf         = 1'b0;
      nf         = 1'b0;
      halted     = 1'b0;
      cycles     = '0;
      mismatches = 0;
    endfunction

    function void update_flags(logic [31:0] v);
      zf = (v == 32'd0);
      nf = v[31];
    endfunction

    // Execute one accepted instruction and queue the report it causes.
    function void note_instruction(op_e op, logic [3:0] d, logic [3:0] s,
                                   logic [31:0] imm, logic [7:0] off);
      logic [31:0]     v;
      logic [PC_W-1:0] rel;
      result_t         rep;
      rel = PC_W'(2) + {{(PC_W-8){off[7]}}, off};
      if (op == OP_START) begin
        foreach (regs[i]) regs[i] = '0;
        regs[0] = imm;
        pc      = '0;
        zf      = 1'b0;
        nf      = 1'b0;
        cycles  = '0;
        halted  = 1'b0;
      end else if (!halted) begin
        case (op)
          OP_RET: begin
            pc     = pc + PC_W'(1);
            cycles = cycles + 32'd1;
            halted = 1'b1;
          end
          OP_ADD: begin
            v       = regs[d] + regs[s];
            regs[d] = v;
            update_flags(v);
            pc      = pc + PC_W'(2);
            cycles  = cycles + 32'd2;
          end
          OP_SUB: begin
            v       = regs[d] - regs[s];
            regs[d] = v;
            update_flags(v);
            pc      = pc + PC_W'(2);
            cycles  = cycles + 32'd2;
          end
          OP_MOV: begin
            regs[d] = regs[s];
            pc      = pc + PC_W'(2);
            cycles  = cycles + 32'd2;
          end
          OP_MOVI: begin
            regs[d] = imm;
            pc      = pc + PC_W'(6);
            cycles  = cycles + 32'd6;
          end
          OP_BR: begin
            pc     = pc + rel;
            cycles = cycles + 32'd2;
          end
          default: begin
            // branch if not zero: falls through by the instruction length
            pc     = zf ? pc + PC_W'(2) : pc + rel;
            cycles = cycles + 32'd2;
          end
        endcase
      end
      rep               = '0;
      rep.fetch_address = FETCH_W'(pc);
      rep.finished      = halted;
      rep.return_value  = regs[0];
      rep.total_cycles  = cycles;
      rep.zero_flag     = zf;
      rep.negative_flag = nf;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one result transaction against the oldest owed report.
    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        $error("result transaction with no instruction outstanding");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("fetch_address", 32'(want.fetch_address), 32'(got.fetch_address));
      compare_field("finished", 32'(want.finished), 32'(got.finished));
      compare_field("return_value", want.return_value, got.return_value);
      compare_field("total_cycles", want.total_cycles, got.total_cycles);
      compare_field("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
      compare_field("negative_flag", 32'(want.negative_flag), 32'(got.negative_flag));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [3:0] dest, [7:4] src, [39:8] imm, [47:40] offset
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // [2:0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [15:0] fetch, [16] finished, [48:17] r0,
                                          // [80:49] cycles, [81] zero, [82] negative

  core_state_tracker tracker;
  int  idle_cycles;
  int  stall_left;
  bit  quiet;

  bytecode_register_machine_core_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: ready mostly high, with random stall bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (!quiet && rst_ni && $urandom_range(0, 9) == 0) begin
      stall_left    = $urandom_range(0, 7);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Check results and count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_report(result_t'(m_axis_tdata[RESULT_W-1:0]));
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: end the run when the core stops moving.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Present one instruction and hold it until the core takes it.
  task automatic send_instruction(op_e op, logic [3:0] d, logic [3:0] s,
                                  logic [31:0] imm, logic [7:0] off);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {off, imm, s, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_instruction(op, d, s, imm, off);
  endtask

  // Drop valid for a number of cycles.
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
  endtask

  // Drop valid and wait until every owed report has come back.
  task automatic drain_core();
    hold_off(1);
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // Mix of boundary values, small values and full random words.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7fff_ffff;
          3: return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int   counted;
    int   pauses_done;
    int   r;
    op_e  op;
    logic [3:0] d;
    logic [3:0] s;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_RET;
    m_axis_tready = 1'b0;
    idle_cycles   = 0;
    stall_left    = 0;
    quiet         = 1'b0;
    tracker       = new;
    tracker.clear_state();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Run on the reset state before any start.
    send_instruction(OP_ADD,  4'd0,  4'd0,  32'h1234_5678, 8'h00);
    send_instruction(OP_BNZ,  4'd3,  4'd9,  32'h0,         8'h05);  // zero set: fall through
    send_instruction(OP_START, 4'd7, 4'd2,  32'h7fff_ffff, 8'h80);
    send_instruction(OP_MOVI, 4'd1,  4'd15, 32'h8000_0000, 8'hff);  // src ignored
    send_instruction(OP_ADD,  4'd0,  4'd1,  32'h0,         8'h00);  // 0xffffffff, negative
    send_instruction(OP_MOVI, 4'd2,  4'd0,  32'h0000_0001, 8'h00);
    send_instruction(OP_ADD,  4'd0,  4'd2,  32'h0,         8'h00);  // wraps to zero
    send_instruction(OP_SUB,  4'd3,  4'd2,  32'h0,         8'h00);  // 0 - 1, negative
    send_instruction(OP_SUB,  4'd1,  4'd1,  32'h0,         8'h00);  // self subtract, zero
    send_instruction(OP_MOV,  4'd15, 4'd3,  32'hffff_ffff, 8'h7f);
    send_instruction(OP_MOV,  4'd0,  4'd15, 32'h0,         8'h00);
    send_instruction(OP_BR,   4'd0,  4'd0,  32'h0,         8'h80);  // pc wraps below zero
    send_instruction(OP_BR,   4'd15, 4'd15, 32'h0,         8'h7f);
    send_instruction(OP_BR,   4'd0,  4'd0,  32'h0,         8'h7f);  // largest forward offset again
    send_instruction(OP_MOVI, 4'd15, 4'd0,  32'hffff_ffff, 8'h00);
    send_instruction(OP_ADD,  4'd15, 4'd2,  32'h0,         8'h00);  // zero flag set
    send_instruction(OP_BNZ,  4'd0,  4'd0,  32'h0,         8'h80);  // not taken
    send_instruction(OP_ADD,  4'd0,  4'd2,  32'h0,         8'h00);  // wraps to zero, zero stays set
    send_instruction(OP_BNZ,  4'd0,  4'd0,  32'h0,         8'h80);  // not taken
    send_instruction(OP_RET,  4'd5,  4'd6,  32'hdead_beef, 8'h11);
    // Halted: everything but start leaves the state alone.
    send_instruction(OP_ADD,  4'd0,  4'd0,  32'h0,         8'h00);
    send_instruction(OP_MOVI, 4'd0,  4'd1,  32'h5555_5555, 8'h00);
    send_instruction(OP_RET,  4'd0,  4'd0,  32'h0,         8'h00);
    send_instruction(OP_START, 4'd0, 4'd0,  32'h8000_0000, 8'h00);
    send_instruction(OP_START, 4'd0, 4'd0,  32'hffff_ffff, 8'h00);

    // Let the directed part fully drain before the random program.
    drain_core();

    counted     = 0;
    pauses_done = 0;
    while (counted < PROGRAM_LEN) begin
      if (counted >= PROGRAM_LEN - QUIET_TAIL)
        quiet = 1'b1;
      if (counted >= (pauses_done + 1) * PAUSE_EVERY) begin
        drain_core();
        pauses_done++;
      end
      if (!quiet && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 8));

      d = 4'($urandom);
      s = ($urandom_range(0, 4) == 0) ? d : 4'($urandom);
      if (tracker.halted) begin
        // Halted: a few ignored items, then a fresh start.
        if ($urandom_range(0, 2) != 0) begin
          send_instruction(op_e'($urandom_range(0, 6)), d, s, $urandom, 8'($urandom));
        end else begin
          send_instruction(OP_START, d, s, pick_word(), 8'($urandom));
          counted++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2)
          op = OP_START;
        else if (r < 5)
          op = OP_RET;
        else if (r < 13)
          op = op_e'($urandom_range(0, 7));
        else
          op = op_e'($urandom_range(1, 6));
        send_instruction(op, d, s, pick_word(), 8'($urandom));
        counted++;
      end
    end

    // Drain, then allow for the pipeline depth so stray results show up.
    drain_core();
    repeat (8) @(posedge clk_i);

    if (tracker.expected_reports.size() != 0) begin
      $error("%0d results never arrived", tracker.expected_reports.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/brmc_pkg.sv
hw/rtl/brmc_front.sv
hw/rtl/brmc_queue.sv
hw/rtl/brmc_back.sv
hw/rtl/bytecode_register_machine_core_top.sv
tb/bytecode_register_machine_core_top_tb.sv
